// ----- hdl/bmf_pkg.sv -----
package bmf_pkg;

  localparam int PIX_W      = 8;
  localparam int HALF_W     = 2;
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int ROW_W      = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int MAX_HEIGHT = 4096;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_WINDOW_HALF  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    op_t              op;
    logic [PIX_W-1:0] pixel_in;
  } pix_word_t;

  typedef struct packed {
    logic [PIX_W-1:0] mean_out;
    logic             frame_end;
  } res_word_t;

endpackage

// ----- hdl/box_mean_filter_gray_top.sv -----
// Channel | Handshake               | Word
// pix     | pix_valid / pix_stall   | pix_word   (op, pixel_in)
// res     | res_valid / res_stall   | res_word   (mean_out, frame_end)
// cfg     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// While pix_stall is low, one pixel or flush word is taken in every clock; the line store has
// one read and one write port and handles one column per cycle while not stalled.
// Results pass the column read, column cells, sum3 and prod4 registers into res_word.
// Reset is synchronous and returns the block to the start of a frame with default settings.
// A stalled result sits in an output register and a skid register; pix_stall rises only
// when both are full.
module box_mean_filter_gray_top #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HALF  = 3
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 pix_valid,
  output logic                                 pix_stall,
  input  bmf_pkg::pix_word_t                   pix_word,
  output logic                                 res_valid,
  input  logic                                 res_stall,
  output bmf_pkg::res_word_t                   res_word,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bmf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bmf_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import bmf_pkg::*;

  localparam int SIDE = 2 * MAX_HALF + 1;
  localparam int CW   = $clog2(MAX_WIDTH + 1);
  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int XW   = (CW > FW_W) ? CW : FW_W;
  localparam int LW   = $clog2(3 * MAX_WIDTH + 4);
  localparam int CSW  = $clog2(SIDE * 255 + 1);
  localparam int SUMW = $clog2(SIDE * SIDE * 255 + 1);
  localparam int K    = SUMW + 8;
  localparam int RECW = K + 1;
  localparam int PW   = SUMW + RECW;
  localparam logic [RECW-1:0] REC0 = RECW'(2 ** K);
  localparam logic [RECW-1:0] REC1 = RECW'((2 ** K + 8) / 9);
  localparam logic [RECW-1:0] REC2 = RECW'((2 ** K + 24) / 25);
  localparam logic [RECW-1:0] REC3 = RECW'((2 ** K + 48) / 49);

  logic [FW_W-1:0]   frame_width;
  logic [FH_W-1:0]   frame_height;
  logic [HALF_W-1:0] window_half;

  logic [CW-1:0]     w_eff;
  logic [ROW_W-1:0]  h_eff;
  logic [HALF_W-1:0] hf;
  logic [XW-1:0]     fw_x;
  logic [LW-1:0]     lag;
  logic [RECW-1:0]   rec;

  logic [ROW_W-1:0]  in_row;
  logic [ROW_W-1:0]  out_row;
  logic [CW-1:0]     in_col;
  logic [CW-1:0]     out_col;
  logic [LW-1:0]     cnt;
  logic              started;

  logic              en;
  logic              accept;
  logic              in_frame;
  logic              run;
  logic              emit;
  logic              last;
  logic [PIX_W-1:0]  x;
  logic [SIDE-1:0]   rowmask;
  logic [SIDE-1:0]   colmask;

  logic              v2, v3, v4;
  logic              emit1, emit2;
  logic              last1, last2, last3, last4;
  logic [SIDE-1:0]   colmask1, colmask2;
  logic [SUMW-1:0]   sum3;
  logic [PW-1:0]     prod4;

  logic              push;
  logic [CSW-1:0]    colsum;
  logic [CSW-1:0]    cq  [SIDE];
  logic [SUMW-1:0]   acc [SIDE];

  logic              skid_valid;
  res_word_t         skid_word;
  res_word_t         new_word;
  logic              take;

  assign cfg_ready = 1'b1;
  assign en        = !skid_valid;
  assign pix_stall = skid_valid;
  assign accept    = pix_valid && !pix_stall;

  assign fw_x  = XW'(frame_width);
  assign w_eff = (fw_x == '0) ? CW'(1) :
                 (fw_x > XW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(fw_x);
  assign h_eff = (frame_height == '0) ? ROW_W'(1) :
                 (frame_height > ROW_W'(MAX_HEIGHT)) ? ROW_W'(MAX_HEIGHT) : frame_height;
  assign hf    = (int'(window_half) > MAX_HALF) ? HALF_W'(MAX_HALF) : window_half;
  assign lag   = LW'(LW'(hf) * LW'(w_eff)) + LW'(hf);

  always_comb begin
    unique case (hf)
      2'd0:    rec = REC0;
      2'd1:    rec = REC1;
      2'd2:    rec = REC2;
      default: rec = REC3;
    endcase
  end

  assign in_frame = in_row < h_eff;
  assign run      = !in_frame || (pix_word.op == OP_PIXEL);
  assign x        = in_frame ? pix_word.pixel_in : '0;
  assign emit     = started || (cnt == lag);
  assign last     = (out_row == h_eff - ROW_W'(1)) && (out_col == w_eff - CW'(1));

  always_comb begin
    logic [ROW_W+1:0] a;
    logic [ROW_W+1:0] b;
    logic [CW+2:0]    c;
    b = (ROW_W+2)'({hf, 1'b0});
    for (int i = 0; i < SIDE; i++) begin
      a = (ROW_W+2)'(in_row) + (ROW_W+2)'(i);
      rowmask[i] = (i <= 2 * int'(hf)) && (a >= b) && ((a - b) < (ROW_W+2)'(h_eff));
    end
    for (int j = 0; j < SIDE; j++) begin
      c = (CW+3)'(out_col) + (CW+3)'(j) + (CW+3)'(hf);
      colmask[j] = (j + 2 * int'(hf) + 1 >= SIDE) && (c >= (CW+3)'(2 * MAX_HALF)) &&
                   ((c - (CW+3)'(2 * MAX_HALF)) < (CW+3)'(w_eff));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FW_W'(640);
      frame_height <= FH_W'(480);
      window_half  <= HALF_W'(1);
      in_row       <= '0;
      in_col       <= '0;
      out_row      <= '0;
      out_col      <= '0;
      cnt          <= '0;
      started      <= 1'b0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT ||
          cfg_index == REG_WINDOW_HALF) begin
        in_row  <= '0;
        in_col  <= '0;
        out_row <= '0;
        out_col <= '0;
        cnt     <= '0;
        started <= 1'b0;
      end
      if (cfg_index == REG_FRAME_WIDTH) begin
        frame_width <= cfg_data[FW_W-1:0];
      end
      if (cfg_index == REG_FRAME_HEIGHT) begin
        frame_height <= cfg_data[FH_W-1:0];
      end
      if (cfg_index == REG_WINDOW_HALF) begin
        window_half <= cfg_data[HALF_W-1:0];
      end
    end else if (accept && run) begin
      if (emit && last) begin
        in_row  <= '0;
        in_col  <= '0;
        out_row <= '0;
        out_col <= '0;
        cnt     <= '0;
        started <= 1'b0;
      end else begin
        if (in_col == w_eff - CW'(1)) begin
          in_col <= '0;
          in_row <= in_row + ROW_W'(1);
        end else begin
          in_col <= in_col + CW'(1);
        end
        if (emit) begin
          started <= 1'b1;
          if (out_col == w_eff - CW'(1)) begin
            out_col <= '0;
            out_row <= out_row + ROW_W'(1);
          end else begin
            out_col <= out_col + CW'(1);
          end
        end else begin
          cnt <= cnt + LW'(1);
        end
      end
    end
  end

  bmf_column #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HALF  (MAX_HALF),
    .AW        (AW),
    .SIDE      (SIDE),
    .CSW       (CSW)
  ) u_column (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .load         (accept && run),
    .load_col     (in_col[AW-1:0]),
    .load_x       (x),
    .load_rowmask (rowmask),
    .hf           (hf),
    .push         (push),
    .colsum       (colsum)
  );

  for (genvar j = 0; j < SIDE; j++) begin : g_cell
    bmf_cell #(
      .CSW  (CSW),
      .SUMW (SUMW)
    ) u_cell (
      .clk     (clk),
      .shift   (push),
      .d       ((j == SIDE - 1) ? colsum : cq[(j + 1) % SIDE]),
      .mask    (colmask2[j]),
      .acc_in  ((j == 0) ? '0 : acc[(j + SIDE - 1) % SIDE]),
      .q       (cq[j]),
      .acc_out (acc[j])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v2 <= push;
      v3 <= v2 && emit2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      emit1    <= emit;
      last1    <= emit && last;
      colmask1 <= colmask;
    end
    if (en) begin
      emit2    <= emit1;
      last2    <= last1;
      colmask2 <= colmask1;
      sum3     <= acc[SIDE-1];
      last3    <= last2;
      prod4    <= PW'(sum3) * PW'(rec);
      last4    <= last3;
    end
  end

  assign new_word.mean_out  = prod4[K+PIX_W-1:K];
  assign new_word.frame_end = last4;
  assign take               = res_valid && !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        res_word   <= skid_word;
        res_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (v4) begin
      if (!res_valid || take) begin
        res_word  <= new_word;
        res_valid <= 1'b1;
      end else begin
        skid_word  <= new_word;
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      res_valid <= 1'b0;
    end
  end

endmodule

// ----- hdl/bmf_column.sv -----
module bmf_column #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HALF  = 3,
  parameter int AW        = 10,
  parameter int SIDE      = 7,
  parameter int CSW       = 11
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    load,
  input  logic [AW-1:0]           load_col,
  input  logic [bmf_pkg::PIX_W-1:0] load_x,
  input  logic [SIDE-1:0]         load_rowmask,
  input  logic [bmf_pkg::HALF_W-1:0] hf,
  output logic                    push,
  output logic [CSW-1:0]          colsum
);
  import bmf_pkg::*;

  localparam int SLOTS = 2 * MAX_HALF;
  localparam int LW    = SLOTS * PIX_W;

  logic [LW-1:0]    mem [MAX_WIDTH];
  logic [LW-1:0]    rdata;
  logic [LW-1:0]    wword;
  logic [LW-1:0]    old_word;
  logic [LW-1:0]    new_word;
  logic             v1;
  logic             fwd1;
  logic [AW-1:0]    col1;
  logic [PIX_W-1:0] x1;
  logic [SIDE-1:0]  mask1;

  assign push     = v1 && en;
  assign old_word = fwd1 ? wword : rdata;
  assign new_word = {old_word[LW-PIX_W-1:0], x1};

  always_comb begin
    logic [PIX_W-1:0] px;
    logic [CSW-1:0]   acc;
    int               slot;
    acc = '0;
    for (int i = 0; i < SIDE; i++) begin
      slot = 2 * int'(hf) - 1 - i;
      if (i == 2 * int'(hf)) begin
        px = x1;
      end else if (i < 2 * int'(hf)) begin
        px = old_word[PIX_W*slot +: PIX_W];
      end else begin
        px = '0;
      end
      if (mask1[i]) begin
        acc = acc + CSW'(px);
      end
    end
    colsum = acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rdata <= mem[load_col];
      col1  <= load_col;
      x1    <= load_x;
      mask1 <= load_rowmask;
      fwd1  <= v1 && (col1 == load_col);
    end
    if (push) begin
      mem[col1] <= new_word;
      wword     <= new_word;
    end
  end

endmodule

// ----- hdl/bmf_cell.sv -----
module bmf_cell #(
  parameter int CSW  = 11,
  parameter int SUMW = 14
) (
  input  logic            clk,
  input  logic            shift,
  input  logic [CSW-1:0]  d,
  input  logic            mask,
  input  logic [SUMW-1:0] acc_in,
  output logic [CSW-1:0]  q,
  output logic [SUMW-1:0] acc_out
);

  assign acc_out = mask ? acc_in + SUMW'(q) : acc_in;

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule

// ----- hdl/bmf_checker.sv -----
module bmf_checker (
  input logic               clk,
  input logic               rst,
  input logic               pix_stall,
  input logic               res_valid,
  input logic               res_stall,
  input bmf_pkg::res_word_t res_word
);
  import bmf_pkg::*;

  a_reset_clears: assert property (@(posedge clk) rst |=> !res_valid && !pix_stall)
    else $error("Reset did not clear the output side.");

  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    pix_stall |-> res_valid)
    else $error("Input stalled with no result waiting.");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_word))
    else $error("Stalled result word changed.");

endmodule

bind box_mean_filter_gray_top bmf_checker u_bmf_checker (
  .clk       (clk),
  .rst       (rst),
  .pix_stall (pix_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res_word  (res_word)
);

// ----- sim/box_mean_filter_gray_top_test.sv -----
`timescale 1ns / 100ps

module box_mean_filter_gray_top_test;
  import bmf_pkg::*;

  localparam int MAXW = 1024;
  localparam int MAXH = 3;
  localparam int SLOTS = 2 * MAXH;
  localparam int SIDE = 2 * MAXH + 1;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk;
  logic rst;
  logic pix_valid;
  logic pix_stall;
  pix_word_t pix_word;
  logic res_valid;
  logic res_stall;
  res_word_t res_word;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  box_mean_filter_gray_top dut (
    .clk(clk), .rst(rst),
    .pix_valid(pix_valid), .pix_stall(pix_stall), .pix_word(pix_word),
    .res_valid(res_valid), .res_stall(res_stall), .res_word(res_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  pix_word_t pending_pixels[$];
  res_word_t expected_means[$];

  logic [7:0] line_hist[0:SLOTS*MAXW-1];
  logic [7:0] win[0:SIDE-1][0:SIDE-1];
  int unsigned width_reg, height_reg, half_reg;
  int unsigned in_row, in_col, out_row, out_col;

  int mismatches;
  int results_seen;
  int frames_seen;
  int random_items;
  int idle_cycles;
  int burst_left;
  int gap_left;
  int stall_mode;
  int stall_left;
  int stall_phase;

  function automatic void clear_positions();
    in_row = 0;
    in_col = 0;
    out_row = 0;
    out_col = 0;
  endfunction

  function automatic void apply_config(cfg_reg_t idx, int unsigned value);
    case (idx)
      REG_FRAME_WIDTH: width_reg = value & 'h7FF;
      REG_FRAME_HEIGHT: height_reg = value & 'h1FFF;
      REG_WINDOW_HALF: half_reg = value & 'h3;
      default: return;
    endcase
    clear_positions();
  endfunction

  function automatic void predict_mean(input pix_word_t wd);
    int unsigned w, h, hf, side, first, c, n, lag, sum;
    int col, row;
    logic [7:0] x;
    logic [7:0] vec[0:SIDE-1];
    res_word_t r;
    w = (width_reg < 1) ? 1 : (width_reg > MAXW) ? MAXW : width_reg;
    h = (height_reg < 1) ? 1 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
    hf = (half_reg > MAXH) ? MAXH : half_reg;
    if (in_row < h) begin
      if (wd.op == OP_FLUSH) return;
      x = wd.pixel_in;
    end else begin
      x = 8'd0;
    end
    side = 2 * hf + 1;
    first = SIDE - side;
    c = (in_col >= MAXW) ? MAXW - 1 : in_col;
    for (int i = 0; i < SIDE; i++) vec[i] = 8'd0;
    for (int i = 0; i < 2 * hf; i++) vec[i] = line_hist[(2 * hf - 1 - i) * MAXW + c];
    vec[2 * hf] = x;
    for (int j = SLOTS - 1; j >= 1; j--) line_hist[j * MAXW + c] = line_hist[(j - 1) * MAXW + c];
    line_hist[c] = x;
    for (int t = 0; t < SIDE - 1; t++)
      for (int i = 0; i < SIDE; i++) win[t][i] = win[t + 1][i];
    for (int i = 0; i < SIDE; i++) win[SIDE - 1][i] = vec[i];
    n = in_row * w + in_col;
    lag = hf * w + hf;
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (n < lag) return;
    sum = 0;
    for (int t = 0; t < side; t++) begin
      col = int'(out_col) + t - int'(hf);
      if (col < 0 || col >= int'(w)) continue;
      for (int i = 0; i < side; i++) begin
        row = int'(out_row) + i - int'(hf);
        if (row < 0 || row >= int'(h)) continue;
        sum += win[first + t][i];
      end
    end
    r.mean_out = 8'((sum / (side * side)) & 'hFF);
    r.frame_end = (out_row == h - 1 && out_col == w - 1);
    expected_means.push_back(r);
    if (r.frame_end) begin
      clear_positions();
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
      pix_word <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!pix_valid || !pix_stall) begin
      if (pix_valid) predict_mean(pix_word);
      if (gap_left > 0 || pending_pixels.size() == 0) begin
        pix_valid <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        pix_word <= pending_pixels.pop_front();
        pix_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
      stall_mode <= 0;
      stall_left <= 0;
      stall_phase <= 0;
    end else begin
      if (res_valid && !res_stall) begin
        results_seen++;
        if (expected_means.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected result: mean %0d end %0b", res_word.mean_out,
                     res_word.frame_end);
        end else begin
          res_word_t e;
          e = expected_means.pop_front();
          if (e.frame_end) frames_seen++;
          if (e.mean_out !== res_word.mean_out || e.frame_end !== res_word.frame_end) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Result %0d: expected mean %0d end %0b, got mean %0d end %0b",
                       results_seen, e.mean_out, e.frame_end, res_word.mean_out,
                       res_word.frame_end);
          end
        end
      end
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        stall_left <= $urandom_range(16, 96);
      end else begin
        stall_left <= stall_left - 1;
      end
      stall_phase <= stall_phase + 1;
      case (stall_mode)
        0: res_stall <= 1'b0;
        1: res_stall <= ($urandom_range(0, 9) < 3);
        default: res_stall <= (stall_phase % 4 != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (pix_valid && !pix_stall) || (res_valid && !res_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout with %0d results outstanding", expected_means.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_pixels.size() != 0 || pix_valid || expected_means.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, int unsigned value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(value);
    do @(posedge clk);
    while (!cfg_ready);
    apply_config(idx, value);
    cfg_valid <= 1'b0;
  endtask

  task automatic setup(int unsigned w, int unsigned h, int unsigned hf);
    wait_idle();
    case ($urandom_range(0, 1))
      0: begin
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        write_reg(REG_WINDOW_HALF, hf);
      end
      default: begin
        write_reg(REG_WINDOW_HALF, hf);
        write_reg(REG_FRAME_HEIGHT, h);
        write_reg(REG_FRAME_WIDTH, w);
      end
    endcase
  endtask

  function automatic logic [7:0] pick_pixel();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic int queue_frame(int unsigned w, int unsigned h, int unsigned hf,
                                     int noise, int cut);
    int unsigned ew, eh, npix, ntail;
    int count;
    pix_word_t wd;
    ew = (w < 1) ? 1 : (w > MAXW) ? MAXW : w;
    eh = (h < 1) ? 1 : (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
    npix = ew * eh;
    ntail = hf * ew + hf;
    if (cut) npix = $urandom_range(1, npix);
    count = 0;
    for (int unsigned k = 0; k < npix; k++) begin
      if (noise && $urandom_range(0, 19) == 0) begin
        wd.op = OP_FLUSH;
        wd.pixel_in = 8'($urandom);
        pending_pixels.push_back(wd);
      end
      wd.op = OP_PIXEL;
      wd.pixel_in = pick_pixel();
      pending_pixels.push_back(wd);
      count++;
    end
    if (cut) return count;
    for (int unsigned k = 0; k < ntail; k++) begin
      wd.op = (noise && $urandom_range(0, 3) == 0) ? OP_PIXEL : OP_FLUSH;
      wd.pixel_in = 8'($urandom);
      pending_pixels.push_back(wd);
      count++;
    end
    return count;
  endfunction

  initial begin
    pix_word_t wd;
    int unsigned w, h, hf;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    random_items = 0;
    width_reg = 640;
    height_reg = 480;
    half_reg = 1;
    clear_positions();
    for (int i = 0; i < SLOTS * MAXW; i++) line_hist[i] = 8'd0;
    for (int t = 0; t < SIDE; t++)
      for (int i = 0; i < SIDE; i++) win[t][i] = 8'd0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed 3x3 frame: extreme pixels, an early flush and a pixel in the tail.
    setup(3, 3, 1);
    wd.op = OP_FLUSH;
    wd.pixel_in = 8'hAA;
    pending_pixels.push_back(wd);
    for (int k = 0; k < 9; k++) begin
      wd.op = OP_PIXEL;
      wd.pixel_in = (k % 2 == 0) ? 8'd255 : 8'd0;
      pending_pixels.push_back(wd);
    end
    wd.op = OP_PIXEL;
    wd.pixel_in = 8'h55;
    pending_pixels.push_back(wd);
    for (int k = 0; k < 3; k++) begin
      wd.op = OP_FLUSH;
      wd.pixel_in = 8'hFF;
      pending_pixels.push_back(wd);
    end
    // Frame shorter than the window lag, and a degenerate single pixel frame.
    setup(5, 1, 3);
    void'(queue_frame(5, 1, 3, 0, 0));
    setup(0, 0, 0);
    void'(queue_frame(0, 0, 0, 0, 0));

    // Register extremes with clamped values; only the start of each frame is sent.
    setup(2047, 1, 0);
    for (int k = 0; k < 64; k++) begin
      wd.op = OP_PIXEL;
      wd.pixel_in = pick_pixel();
      pending_pixels.push_back(wd);
    end
    setup(1, 8191, 1);
    for (int k = 0; k < 64; k++) begin
      wd.op = OP_PIXEL;
      wd.pixel_in = pick_pixel();
      pending_pixels.push_back(wd);
    end

    while (random_items < 360) begin
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 8);
      hf = $urandom_range(0, 3);
      setup(w, h, hf);
      repeat ($urandom_range(1, 3)) begin
        random_items += queue_frame(w, h, hf, $urandom_range(0, 2) != 0,
                                    $urandom_range(0, 9) == 0);
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    $display("Checked %0d filtered pixels over %0d completed frames, window sides 1 to 7,",
             results_seen, frames_seen);
    $display("with random input gaps, output stalls, early flushes and cut frames.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- box_mean_filter_gray_top.f -----
hdl/bmf_pkg.sv
hdl/bmf_column.sv
hdl/bmf_cell.sv
hdl/box_mean_filter_gray_top.sv
hdl/bmf_checker.sv
sim/box_mean_filter_gray_top_test.sv
